@@ rtl/core/jcp_pkg.sv @@
// jcp_pkg: shared types, constants and helper functions of the joint command parser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package jcp_pkg;

   // character codes
   localparam logic [7:0] CharNul  = 8'h00;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   // accumulator saturation limit and its width
   localparam int SpeedMax = 32767;
   localparam int AccW     = $clog2(SpeedMax + 1);
   localparam int SumW     = AccW + 4;
   localparam int SpeedW   = 16;

   // record layout: six joints, then the speed
   localparam int JointCnt = 6;
   localparam int IdxW     = 3;
   localparam int AngleW   = 8;
   localparam int GripW    = 7;
   localparam logic [IdxW-1:0] IdxSpeed = 3'd6;

   // one result item
   typedef struct packed {
      logic [AngleW-1:0]        base_angle;
      logic [AngleW-1:0]        shoulder_angle;
      logic [AngleW-1:0]        elbow_angle;
      logic [AngleW-1:0]        wrist_angle;
      logic [AngleW-1:0]        wrist_turn_angle;
      logic [GripW-1:0]         gripper_angle;
      logic signed [SpeedW-1:0] move_speed;
      logic                     parse_ok;
   } rsp_item_type;

   // lower clamp limit of joint k
   function automatic logic [AngleW-1:0] joint_lo(input logic [IdxW-1:0] k);
      logic [AngleW-1:0] lim;
      unique case (k)
         3'd1:    lim = 8'd15;
         3'd5:    lim = 8'd10;
         default: lim = 8'd0;
      endcase
      return lim;
   endfunction

   // upper clamp limit of joint k
   function automatic logic [AngleW-1:0] joint_hi(input logic [IdxW-1:0] k);
      logic [AngleW-1:0] lim;
      unique case (k)
         3'd1:    lim = 8'd165;
         3'd5:    lim = 8'd73;
         default: lim = 8'd180;
      endcase
      return lim;
   endfunction

   // clamp an accumulator value into the range of joint k
   function automatic logic [AngleW-1:0] clamp_joint(input logic [IdxW-1:0] k,
                                                     input logic [AccW-1:0] v);
      logic [AngleW-1:0] lo;
      logic [AngleW-1:0] hi;
      logic [AngleW-1:0] res;
      lo = joint_lo(k);
      hi = joint_hi(k);
      if (v < AccW'(lo)) begin
         res = lo;
      end else if (v > AccW'(hi)) begin
         res = hi;
      end else begin
         res = v[AngleW-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/core/jcp_if.sv @@
// jcp_req_if / jcp_rsp_if: valid/ready channels for command bytes and parsed records.
// Depends on jcp_pkg for field widths.
`timescale 1ns / 1ps

interface jcp_req_if;
   import jcp_pkg::*;
   logic             valid;
   logic             ready;
   logic [7:0]       char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface jcp_rsp_if;
   import jcp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [AngleW-1:0]        base_angle;
   logic [AngleW-1:0]        shoulder_angle;
   logic [AngleW-1:0]        elbow_angle;
   logic [AngleW-1:0]        wrist_angle;
   logic [AngleW-1:0]        wrist_turn_angle;
   logic [GripW-1:0]         gripper_angle;
   logic signed [SpeedW-1:0] move_speed;
   logic                     parse_ok;

   modport source (output valid, output base_angle, output shoulder_angle,
                   output elbow_angle, output wrist_angle, output wrist_turn_angle,
                   output gripper_angle, output move_speed, output parse_ok,
                   input ready);
   modport sink   (input valid, input base_angle, input shoulder_angle,
                   input elbow_angle, input wrist_angle, input wrist_turn_angle,
                   input gripper_angle, input move_speed, input parse_ok,
                   output ready);
endinterface

@@ rtl/core/jcp_parser.sv @@
// jcp_parser: per-byte parse state, digit accumulation, joint clamping and record build.
// Depends on jcp_pkg; instantiated by joint_command_parser.
`timescale 1ns / 1ps

module jcp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,        // a byte transfers this cycle
   input  logic [7:0]            char_code,
   output logic                  res_valid,   // this byte closes a record
   output jcp_pkg::rsp_item_type res_item
);
   import jcp_pkg::*;

   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              in_num_ff, in_num_in;
   logic [AccW-1:0]   acc_ff, acc_in;
   logic              skip_ff, skip_in;
   logic [AngleW-1:0] joint_ff [JointCnt];

   logic              is_digit;
   logic              is_nul;
   logic [SumW-1:0]   acc_sum;
   logic [AngleW-1:0] clamp_lane [JointCnt];
   logic [AngleW-1:0] joint_eff  [JointCnt];
   logic [AngleW-1:0] joint_out  [JointCnt];
   logic              closes_joint;
   logic              closes_speed;
   logic [IdxW-1:0]   done_cnt;
   logic              emit_ok;
   logic              emit_any;

   assign is_digit = (char_code >= CharZero) && (char_code <= CharNine);
   assign is_nul   = (char_code == CharNul);

   // times-ten accumulate, digit value is the low nibble
   assign acc_sum = SumW'(acc_ff) * SumW'(10) + SumW'(char_code[3:0]);

   // number ends on a non-digit outside skip mode
   assign closes_joint = !skip_ff && !is_digit && in_num_ff && (idx_ff < IdxSpeed);
   assign closes_speed = !skip_ff && !is_digit && in_num_ff && (idx_ff == IdxSpeed);

   // clamp lanes, one per joint; the closing joint bypasses its register
   always_comb begin
      for (int k = 0; k < JointCnt; k++) begin
         clamp_lane[k] = clamp_joint(IdxW'(k), acc_ff);
         joint_eff[k]  = (closes_joint && (idx_ff == IdxW'(k))) ? clamp_lane[k]
                                                                : joint_ff[k];
      end
   end

   // joints found in this record, counting one that closes now
   assign done_cnt = closes_joint ? idx_ff + 3'd1 : idx_ff;
   assign emit_ok  = closes_speed;
   assign emit_any = closes_speed || (!skip_ff && !is_digit && is_nul);

   // missing joints read as the clamp of zero
   always_comb begin
      for (int k = 0; k < JointCnt; k++) begin
         joint_out[k] = (closes_speed || (IdxW'(k) < done_cnt)) ? joint_eff[k]
                                                                 : joint_lo(IdxW'(k));
      end
   end

   always_comb begin
      res_valid                 = take && emit_any;
      res_item.base_angle       = joint_out[0];
      res_item.shoulder_angle   = joint_out[1];
      res_item.elbow_angle      = joint_out[2];
      res_item.wrist_angle      = joint_out[3];
      res_item.wrist_turn_angle = joint_out[4];
      res_item.gripper_angle    = joint_out[5][GripW-1:0];
      res_item.move_speed       = emit_ok ? $signed(SpeedW'(acc_ff)) : '1;
      res_item.parse_ok         = emit_ok;
   end

   // next parse state
   always_comb begin
      idx_in    = idx_ff;
      in_num_in = in_num_ff;
      acc_in    = acc_ff;
      skip_in   = skip_ff;
      if (skip_ff) begin
         if (is_nul) begin
            skip_in = 1'b0;
         end
      end else if (is_digit) begin
         acc_in    = (acc_sum > SumW'(SpeedMax)) ? AccW'(SpeedMax) : acc_sum[AccW-1:0];
         in_num_in = 1'b1;
      end else begin
         in_num_in = 1'b0;
         if (closes_speed) begin
            idx_in  = '0;
            acc_in  = '0;
            skip_in = !is_nul;
         end else begin
            if (closes_joint) begin
               idx_in = idx_ff + 3'd1;
               acc_in = '0;
            end
            if (is_nul) begin
               idx_in = '0;
               acc_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         in_num_ff <= 1'b0;
         acc_ff    <= '0;
         skip_ff   <= 1'b0;
      end else if (take) begin
         idx_ff    <= idx_in;
         in_num_ff <= in_num_in;
         acc_ff    <= acc_in;
         skip_ff   <= skip_in;
      end
   end

   // joint store, no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (take && closes_joint) begin
         joint_ff[idx_ff] <= clamp_lane[idx_ff];
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IdxSpeed)
      else $error("field index beyond speed field");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> !res_valid)
      else $error("result produced while skipping to end of record");

   a_ok_speed: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_item.parse_ok |-> res_item.move_speed == -16'sd1)
      else $error("incomplete record without speed marker");

endmodule

@@ rtl/core/joint_command_parser.sv @@
// joint_command_parser: top level; parser core plus a two-entry result buffer.
// Depends on jcp_pkg, jcp_req_if / jcp_rsp_if and jcp_parser.
//
//   channel | dir | payload                                   | transfer
//   req_bus | in  | char_code                                 | valid && ready
//   rsp_bus | out | six joint angles, move_speed, parse_ok    | valid && ready
//
// One byte per cycle while req_bus.ready is high; a byte is parsed in the cycle
// it transfers, and a record it closes is registered in the output or skid entry.
// A skid entry behind the output register keeps req_bus.ready high while one
// record waits; ready drops only when both entries hold records.
// Synchronous reset clears the parse state and empties both buffer entries.
`timescale 1ns / 1ps

module joint_command_parser (
   input  logic clock,
   input  logic reset,
   jcp_req_if.sink   req_bus,
   jcp_rsp_if.source rsp_bus
);
   import jcp_pkg::*;

   logic         take;
   logic         res_valid;
   rsp_item_type res_item;

   logic         main_vld_ff, main_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign req_bus.ready = !skid_vld_ff;
   assign take          = req_bus.valid && req_bus.ready;
   assign pop           = main_vld_ff && rsp_bus.ready;

   jcp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_bus.char_code),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // two-entry result buffer
   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            main_in     = res_item;
            main_vld_in = res_valid;
         end
      end else if (res_valid) begin
         if (main_vld_ff) begin
            skid_in     = res_item;
            skid_vld_in = 1'b1;
         end else begin
            main_in     = res_item;
            main_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid            = main_vld_ff;
   assign rsp_bus.base_angle       = main_ff.base_angle;
   assign rsp_bus.shoulder_angle   = main_ff.shoulder_angle;
   assign rsp_bus.elbow_angle      = main_ff.elbow_angle;
   assign rsp_bus.wrist_angle      = main_ff.wrist_angle;
   assign rsp_bus.wrist_turn_angle = main_ff.wrist_turn_angle;
   assign rsp_bus.gripper_angle    = main_ff.gripper_angle;
   assign rsp_bus.move_speed       = main_ff.move_speed;
   assign rsp_bus.parse_ok         = main_ff.parse_ok;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid entry holds a record while output register is empty");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      res_valid && main_vld_ff && !pop |-> !skid_vld_ff)
      else $error("record arrives with both buffer entries full");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(main_ff))
      else $error("waiting record changed before its transfer");

endmodule
